>>> rtl/core/lsps_pkg.sv
package lsps_pkg;

    localparam int ROW_COUNT_DEF         = 4;
    localparam int UPDATE_TIMEOUT_MS_DEF = 3000;
    localparam int OUT_ROWS              = 4;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [7:0] DEF_HUE     = 8'd210;
    localparam logic [7:0] DEF_RATE    = 8'd10;
    localparam logic [7:0] DEF_BLINKS  = 8'd2;
    localparam logic [7:0] DEF_PAUSES  = 8'd1;
    localparam logic [7:0] DEF_REPEATS = 8'd255;
    localparam logic [7:0] ENDLESS     = 8'd255;

    localparam logic [9:0] DIVIDEND  = 10'd1000;
    localparam logic [3:0] DIV_STEPS = 4'd10;

    typedef struct packed {
        logic       operation;
        logic [7:0] hue;
        logic [7:0] rate;
        logic [7:0] blink_count;
        logic [7:0] pause_count;
        logic [7:0] repeat_count;
    } t_in_word;

    typedef struct packed {
        logic       row0_lit;
        logic       row1_lit;
        logic       row2_lit;
        logic       row3_lit;
        logic [7:0] row0_hue;
        logic [7:0] row1_hue;
        logic [7:0] row2_hue;
        logic [7:0] row3_hue;
    } t_out_word;

    typedef struct packed {
        logic load_status;
        logic start_div;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

>>> rtl/core/lsps_ctrl.sv
module lsps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lsps_pkg::t_dp_cmd o_cmd,
    input  lsps_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_STEP = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == lsps_pkg::OP_UPDATE) begin
                        o_cmd.load_status = 1'b1;
                    end else begin
                        o_cmd.start_div = 1'b1;
                        n_state         = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_tick_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_in_op == lsps_pkg::OP_TICK)
        |=> (r_state == ST_DIV))
        else $error("tick word did not start the divider");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && !i_sts.div_done) |=> (r_state == ST_DIV))
        else $error("left the divide state before the quotient was ready");

    a_valid_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_STEP))
        else $error("result raised outside the step state");

endmodule

>>> rtl/core/lsps_dp.sv
module lsps_dp #(
    parameter int ROW_COUNT         = lsps_pkg::ROW_COUNT_DEF,
    parameter int UPDATE_TIMEOUT_MS = lsps_pkg::UPDATE_TIMEOUT_MS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsps_pkg::t_dp_cmd   i_cmd,
    output lsps_pkg::t_dp_sts   o_sts,
    input  lsps_pkg::t_in_word  i_in_word,
    output lsps_pkg::t_out_word o_out_word
);

    localparam int FS_W = $clog2(ROW_COUNT + 1);

    logic [7:0]      r_hue, n_hue;
    logic [7:0]      r_rate, n_rate;
    logic [7:0]      r_blinks, n_blinks;
    logic [7:0]      r_pauses, n_pauses;
    logic [7:0]      r_repeats, n_repeats;
    logic [9:0]      r_fe, n_fe;
    logic [11:0]     r_ue, n_ue;
    logic [9:0]      r_bs, n_bs;
    logic [8:0]      r_bos, n_bos;
    logic [7:0]      r_brd, n_brd;
    logic [FS_W-1:0] r_fs, n_fs;
    logic [7:0]      r_frd, n_frd;
    logic            r_lit [ROW_COUNT];
    logic            n_lit [ROW_COUNT];
    logic [7:0]      r_rhue [ROW_COUNT];
    logic [7:0]      n_rhue [ROW_COUNT];

    logic [9:0]      r_quo;
    logic [8:0]      r_rem;
    logic [3:0]      r_cnt;
    logic [9:0]      w_rem_sh;
    logic            w_ge;

    lsps_pkg::t_out_word r_out;
    logic            w_lit [lsps_pkg::OUT_ROWS];
    logic [7:0]      w_rhue [lsps_pkg::OUT_ROWS];

    // Restoring divider for the frame interval, one quotient bit per cycle.
    assign w_rem_sh = {r_rem, r_quo[9]};
    assign w_ge     = (w_rem_sh >= {2'b00, r_rate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo <= '0;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.start_div) begin
            r_quo <= lsps_pkg::DIVIDEND;
            r_rem <= '0;
            r_cnt <= lsps_pkg::DIV_STEPS;
        end else if (r_cnt != 4'd0) begin
            r_quo <= {r_quo[8:0], w_ge};
            r_rem <= w_ge ? 9'(w_rem_sh - {2'b00, r_rate}) : w_rem_sh[8:0];
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_sts.div_done = (r_cnt == 4'd0);

    always_comb begin
        logic [9:0]    fe1;
        logic          due;
        logic [8:0]    cyc;
        logic          done;
        logic          on;
        logic [8:0]    bos1;
        logic [FS_W:0] fs_inc;

        n_hue     = r_hue;
        n_rate    = r_rate;
        n_blinks  = r_blinks;
        n_pauses  = r_pauses;
        n_repeats = r_repeats;
        n_fe      = r_fe;
        n_ue      = r_ue;
        n_bs      = r_bs;
        n_bos     = r_bos;
        n_brd     = r_brd;
        n_fs      = r_fs;
        n_frd     = r_frd;
        n_lit     = r_lit;
        n_rhue    = r_rhue;

        fe1    = (r_fe == 10'd1023) ? r_fe : r_fe + 10'd1;
        due    = (fe1 >= r_quo);
        cyc    = {1'b0, r_blinks} + {1'b0, r_pauses};
        done   = (r_brd >= r_repeats) && (r_bs >= {cyc, 1'b0});
        on     = (r_bos < {1'b0, r_blinks});
        bos1   = (r_bos == 9'd511) ? r_bos : r_bos + 9'd1;
        fs_inc = {1'b0, r_fs} + (FS_W + 1)'(1);

        if (i_cmd.load_status) begin
            n_hue     = i_in_word.hue;
            n_rate    = i_in_word.rate;
            n_blinks  = i_in_word.blink_count;
            n_pauses  = i_in_word.pause_count;
            n_repeats = i_in_word.repeat_count;
            n_ue      = '0;
        end else if (i_cmd.commit) begin
            n_fe = fe1;
            if (r_rate == 8'd0) begin
                for (int r = 0; r < ROW_COUNT; r++) begin
                    n_lit[r]  = 1'b1;
                    n_rhue[r] = r_hue;
                end
                n_bs  = '0;
                n_bos = '0;
                n_brd = '0;
                n_fs  = '0;
                n_frd = '0;
            end else if (r_blinks == 8'd0) begin
                n_bs  = '0;
                n_bos = '0;
                n_brd = '0;
                if (due) begin
                    n_fe = '0;
                    if (r_frd >= r_repeats || r_fs == '0) begin
                        for (int r = 0; r < ROW_COUNT; r++) begin
                            n_lit[r] = 1'b0;
                        end
                    end else begin
                        for (int r = 0; r < ROW_COUNT; r++) begin
                            if ((FS_W + 1)'(r) < {1'b0, r_fs}) begin
                                n_lit[r]  = 1'b1;
                                n_rhue[r] = r_hue;
                            end
                        end
                    end
                    if (fs_inc > (FS_W + 1)'(ROW_COUNT)) begin
                        n_fs = '0;
                        if (r_repeats != lsps_pkg::ENDLESS && r_frd != 8'd255) begin
                            n_frd = r_frd + 8'd1;
                        end
                    end else begin
                        n_fs = fs_inc[FS_W-1:0];
                    end
                end
            end else begin
                n_fs  = '0;
                n_frd = '0;
                if (due) begin
                    n_fe = '0;
                    if (done || !r_bs[0]) begin
                        for (int r = 0; r < ROW_COUNT; r++) begin
                            n_lit[r] = 1'b0;
                        end
                    end else begin
                        for (int r = 0; r < ROW_COUNT; r++) begin
                            n_lit[r] = on;
                            if (on) begin
                                n_rhue[r] = r_hue;
                            end
                        end
                        if (bos1 >= cyc) begin
                            n_bos = '0;
                            if (r_repeats != lsps_pkg::ENDLESS && r_brd != 8'd255) begin
                                n_brd = r_brd + 8'd1;
                            end
                        end else begin
                            n_bos = bos1;
                        end
                    end
                    n_bs = (r_bs == 10'd1023) ? 10'd1022 : r_bs + 10'd1;
                end
            end
            n_ue = (r_ue == 12'd4095) ? r_ue : r_ue + 12'd1;
            if (n_ue > 12'(UPDATE_TIMEOUT_MS)) begin
                n_hue     = lsps_pkg::DEF_HUE;
                n_rate    = lsps_pkg::DEF_RATE;
                n_blinks  = lsps_pkg::DEF_BLINKS;
                n_pauses  = lsps_pkg::DEF_PAUSES;
                n_repeats = lsps_pkg::DEF_REPEATS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue     <= lsps_pkg::DEF_HUE;
            r_rate    <= lsps_pkg::DEF_RATE;
            r_blinks  <= lsps_pkg::DEF_BLINKS;
            r_pauses  <= lsps_pkg::DEF_PAUSES;
            r_repeats <= lsps_pkg::DEF_REPEATS;
            r_fe      <= '0;
            r_ue      <= '0;
            r_bs      <= '0;
            r_bos     <= '0;
            r_brd     <= '0;
            r_fs      <= '0;
            r_frd     <= '0;
            for (int r = 0; r < ROW_COUNT; r++) begin
                r_lit[r]  <= 1'b0;
                r_rhue[r] <= 8'd0;
            end
        end else begin
            r_hue     <= n_hue;
            r_rate    <= n_rate;
            r_blinks  <= n_blinks;
            r_pauses  <= n_pauses;
            r_repeats <= n_repeats;
            r_fe      <= n_fe;
            r_ue      <= n_ue;
            r_bs      <= n_bs;
            r_bos     <= n_bos;
            r_brd     <= n_brd;
            r_fs      <= n_fs;
            r_frd     <= n_frd;
            r_lit     <= n_lit;
            r_rhue    <= n_rhue;
        end
    end

    for (genvar g = 0; g < lsps_pkg::OUT_ROWS; g++) begin : g_out_row
        if (g < ROW_COUNT) begin : g_used
            assign w_lit[g]  = n_lit[g];
            assign w_rhue[g] = n_rhue[g];
        end else begin : g_unused
            assign w_lit[g]  = 1'b0;
            assign w_rhue[g] = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.row0_lit <= w_lit[0];
            r_out.row1_lit <= w_lit[1];
            r_out.row2_lit <= w_lit[2];
            r_out.row3_lit <= w_lit[3];
            r_out.row0_hue <= w_rhue[0];
            r_out.row1_hue <= w_rhue[1];
            r_out.row2_hue <= w_rhue[2];
            r_out.row3_hue <= w_rhue[3];
        end
    end

    assign o_out_word = r_out;

endmodule

>>> rtl/core/led_status_pattern_sequencer_unit.sv
// LED status pattern sequencer for a panel of ROW_COUNT rows.
// The input channel (i_in_valid, o_in_ready, i_in_word) takes one word per
// millisecond tick or per status update. A status update loads hue, rate,
// blink, pause and repeat counts, and gives no result. A tick gives exactly
// one result word on the output channel (o_out_valid, i_out_ready,
// o_out_word) with the lit state and hue of rows 0 to 3. A tick first runs
// the restoring divider that forms the frame interval 1000/rate one quotient
// bit per cycle, waits in the divide state until the quotient is ready, and
// then applies the step and loads the result in the step state. The input is
// ready again in the cycle after the result is loaded; updates are taken in
// back-to-back cycles.
// The result sits in an output register, so the next word is accepted while a
// finished result waits. If the receiver stalls, the next tick stops in its
// step state until the output register is free, and the input stays not ready.
// Reset is synchronous and active low; it loads the default status (hue 210,
// rate 10, two blinks, one pause, endless repeats), clears all counters and
// darkens every row with hue 0.
module led_status_pattern_sequencer_unit #(
    parameter int ROW_COUNT         = lsps_pkg::ROW_COUNT_DEF,
    parameter int UPDATE_TIMEOUT_MS = lsps_pkg::UPDATE_TIMEOUT_MS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lsps_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsps_pkg::t_out_word o_out_word
);

    lsps_pkg::t_dp_cmd w_cmd;
    lsps_pkg::t_dp_sts w_sts;

    lsps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_op     (i_in_word.operation),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lsps_dp #(
        .ROW_COUNT         (ROW_COUNT),
        .UPDATE_TIMEOUT_MS (UPDATE_TIMEOUT_MS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

>>> bench/panel_checker.sv
`timescale 1ns / 100ps

module panel_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lsps_pkg::t_in_word  i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lsps_pkg::t_out_word i_out_word,
    output int                  o_fail_count,
    output int                  o_pending
);

    logic [7:0]                         hue_q;
    logic [7:0]                         rate_q;
    logic [7:0]                         blinks_q;
    logic [7:0]                         pauses_q;
    logic [7:0]                         repeats_q;
    logic [9:0]                         interval_q;
    logic [9:0]                         frame_cnt;
    logic [11:0]                        quiet_cnt;
    logic [9:0]                         blink_pos;
    logic [8:0]                         on_pos;
    logic [7:0]                         blink_reps;
    logic [2:0]                         fount_pos;
    logic [7:0]                         fount_reps;
    logic [lsps_pkg::ROW_COUNT_DEF-1:0] row_on;
    logic [7:0]                         row_hue [lsps_pkg::ROW_COUNT_DEF];
    lsps_pkg::t_out_word                expected_panels [$];
    int                                 mismatches = 0;

    function automatic void restore_status();
        hue_q     = lsps_pkg::DEF_HUE;
        rate_q    = lsps_pkg::DEF_RATE;
        blinks_q  = lsps_pkg::DEF_BLINKS;
        pauses_q  = lsps_pkg::DEF_PAUSES;
        repeats_q = lsps_pkg::DEF_REPEATS;
    endfunction

    function automatic void clear_blink();
        blink_pos  = '0;
        on_pos     = '0;
        blink_reps = '0;
    endfunction

    function automatic void clear_fountain();
        fount_pos  = '0;
        fount_reps = '0;
    endfunction

    // A dark row keeps the hue it last had.
    function automatic void light_row(input int r, input bit lit);
        if (r < lsps_pkg::ROW_COUNT_DEF) begin
            row_on[r] = lit;
            if (lit) begin
                row_hue[r] = hue_q;
            end
        end
    endfunction

    function automatic void light_rows(input bit lit);
        for (int r = 0; r < lsps_pkg::ROW_COUNT_DEF; r++) begin
            light_row(r, lit);
        end
    endfunction

    function automatic lsps_pkg::t_out_word panel_after_tick();
        lsps_pkg::t_out_word w;
        int                  cycle;
        bit                  finished;
        bit                  fire;
        if (frame_cnt < 10'd1023) begin
            frame_cnt = frame_cnt + 10'd1;
        end
        if (rate_q == 8'd0) begin
            light_rows(1'b1);
            clear_blink();
            clear_fountain();
        end else begin
            interval_q = 10'(1000 / int'(rate_q));
            fire = (frame_cnt >= interval_q);
            if (fire) begin
                frame_cnt = '0;
            end
            if (blinks_q == 8'd0) begin
                if (fire) begin
                    if (fount_reps >= repeats_q || fount_pos == 3'd0) begin
                        light_rows(1'b0);
                    end else begin
                        for (int r = 0;
                             r < int'(fount_pos) && r < lsps_pkg::ROW_COUNT_DEF;
                             r++) begin
                            light_row(r, 1'b1);
                        end
                    end
                    fount_pos = fount_pos + 3'd1;
                    if (int'(fount_pos) > lsps_pkg::ROW_COUNT_DEF) begin
                        fount_pos = '0;
                        if (repeats_q != lsps_pkg::ENDLESS && fount_reps < 8'd255) begin
                            fount_reps = fount_reps + 8'd1;
                        end
                    end
                end
                clear_blink();
            end else begin
                if (fire) begin
                    cycle = int'(blinks_q) + int'(pauses_q);
                    finished = (blink_reps >= repeats_q) && (int'(blink_pos) >= 2 * cycle);
                    if (finished || !blink_pos[0]) begin
                        light_rows(1'b0);
                    end else begin
                        light_rows(int'(on_pos) < int'(blinks_q));
                        if (on_pos < 9'd511) begin
                            on_pos = on_pos + 9'd1;
                        end
                        if (int'(on_pos) >= cycle) begin
                            on_pos = '0;
                            if (repeats_q != lsps_pkg::ENDLESS && blink_reps < 8'd255) begin
                                blink_reps = blink_reps + 8'd1;
                            end
                        end
                    end
                    if (blink_pos >= 10'd1023) begin
                        blink_pos = 10'd1022;
                    end else begin
                        blink_pos = blink_pos + 10'd1;
                    end
                end
                clear_fountain();
            end
        end
        if (quiet_cnt < 12'd4095) begin
            quiet_cnt = quiet_cnt + 12'd1;
        end
        if (int'(quiet_cnt) > lsps_pkg::UPDATE_TIMEOUT_MS_DEF) begin
            restore_status();
        end
        w.row0_lit = row_on[0];
        w.row1_lit = row_on[1];
        w.row2_lit = row_on[2];
        w.row3_lit = row_on[3];
        w.row0_hue = row_hue[0];
        w.row1_hue = row_hue[1];
        w.row2_hue = row_hue[2];
        w.row3_hue = row_hue[3];
        return w;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        lsps_pkg::t_out_word want;
        if (!i_rst_n) begin
            restore_status();
            interval_q = 10'd100;
            frame_cnt  = '0;
            quiet_cnt  = '0;
            clear_blink();
            clear_fountain();
            row_on = '0;
            for (int r = 0; r < lsps_pkg::ROW_COUNT_DEF; r++) begin
                row_hue[r] = '0;
            end
            expected_panels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_panels.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected, expected none, got %h",
                             $time, i_out_word);
                end else begin
                    want = expected_panels.pop_front();
                    check_field("row0_lit", want.row0_lit, i_out_word.row0_lit);
                    check_field("row1_lit", want.row1_lit, i_out_word.row1_lit);
                    check_field("row2_lit", want.row2_lit, i_out_word.row2_lit);
                    check_field("row3_lit", want.row3_lit, i_out_word.row3_lit);
                    check_field("row0_hue", want.row0_hue, i_out_word.row0_hue);
                    check_field("row1_hue", want.row1_hue, i_out_word.row1_hue);
                    check_field("row2_hue", want.row2_hue, i_out_word.row2_hue);
                    check_field("row3_hue", want.row3_hue, i_out_word.row3_hue);
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_word.operation == lsps_pkg::OP_UPDATE) begin
                    hue_q     = i_in_word.hue;
                    rate_q    = i_in_word.rate;
                    blinks_q  = i_in_word.blink_count;
                    pauses_q  = i_in_word.pause_count;
                    repeats_q = i_in_word.repeat_count;
                    quiet_cnt = '0;
                end else begin
                    expected_panels.push_back(panel_after_tick());
                end
            end
        end
        o_pending    = expected_panels.size();
        o_fail_count = mismatches;
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    lsps_pkg::t_in_word  in_word;
    logic                out_valid;
    logic                out_ready;
    lsps_pkg::t_out_word out_word;
    int                  fails;
    int                  pending;
    bit                  no_idle = 1'b0;
    int                  words_sent = 0;

    led_status_pattern_sequencer_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    panel_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_word  (out_word),
        .o_fail_count(fails),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever begin
            #5 clk = ~clk;
        end
    end

    initial begin
        #(20_000_000);
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_word(input lsps_pkg::t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Tick words carry random content in the fields that a tick ignores.
    task automatic tick_run(input int n);
        repeat (n) begin
            send_word('{lsps_pkg::OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom)});
        end
    endtask

    task automatic post_status(input logic [7:0] hue, input logic [7:0] rate,
                               input logic [7:0] blinks, input logic [7:0] pauses,
                               input logic [7:0] repeats);
        send_word('{lsps_pkg::OP_UPDATE, hue, rate, blinks, pauses, repeats});
    endtask

    initial begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int         first;
        logic [7:0] rate;
        logic [7:0] blinks;
        logic [7:0] pauses;
        logic [7:0] repeats;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        tick_run(3);
        post_status(8'hFF, 8'd0, 8'd0, 8'd0, 8'd0);
        tick_run(2);
        post_status(8'h00, 8'd255, 8'd255, 8'd255, 8'd0);
        tick_run(4);
        post_status(8'hA5, 8'd255, 8'd0, 8'd0, lsps_pkg::ENDLESS);
        tick_run(6);
        post_status(8'h5A, 8'd255, 8'd0, 8'hFF, 8'd0);
        tick_run(3);
        post_status(8'h3C, 8'd1, 8'd1, 8'd0, 8'd1);
        tick_run(2);

        // A long steady light lets the frame timer run into its ceiling.
        post_status(8'($urandom), 8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
        tick_run(1030);
        post_status(8'h81, 8'd1, 8'd0, 8'd0, 8'd2);
        tick_run(3);

        first = words_sent;
        while (words_sent - first < 500) begin
            case ($urandom_range(0, 7))
                0:       rate = 8'd0;
                1:       rate = 8'($urandom_range(1, 9));
                2:       rate = 8'($urandom);
                default: rate = 8'($urandom_range(100, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       blinks = 8'd0;
                1:       blinks = 8'($urandom);
                default: blinks = 8'($urandom_range(1, 4));
            endcase
            pauses = $urandom_range(0, 1) ? 8'($urandom_range(0, 4)) : 8'($urandom);
            case ($urandom_range(0, 3))
                0:       repeats = lsps_pkg::ENDLESS;
                1:       repeats = 8'($urandom);
                default: repeats = 8'($urandom_range(0, 3));
            endcase
            no_idle = ($urandom_range(0, 4) == 0);
            post_status(8'($urandom), rate, blinks, pauses, repeats);
            tick_run($urandom_range(0, 40));
        end
        no_idle = 1'b0;

        // Fast endless blinking, refreshed once, drives the blink step counter into its
        // ceiling; the last stretch without an update then runs past the status timeout
        // until the update timer saturates.
        post_status(8'h66, 8'd255, 8'd3, 8'd2, lsps_pkg::ENDLESS);
        tick_run(1500);
        post_status(8'h66, 8'd255, 8'd3, 8'd2, lsps_pkg::ENDLESS);
        tick_run(4300);
        in_valid <= 1'b0;

        do @(negedge clk); while (pending != 0);
        repeat (30) @(negedge clk);
        if (fails == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lsps_pkg.sv
rtl/core/lsps_ctrl.sv
rtl/core/lsps_dp.sv
rtl/core/led_status_pattern_sequencer_unit.sv
bench/panel_checker.sv
bench/tb.sv
